### sv/olex_pkg.sv
// ----------------------------------------------------------------------------
// Operator token lexer package
// Token kinds, lexer state and result types, and the operator table.
// ----------------------------------------------------------------------------
package olex_pkg;

  typedef enum logic [5:0] {
    KindInvalid, KindLParen, KindRParen, KindLBrack, KindRBrack, KindLBrace,
    KindRBrace, KindTilde, KindIncr, KindDecr, KindBang, KindPlus, KindMinus,
    KindNotEq, KindPlusEq, KindMinusEq, KindAndAnd, KindAndAndEq, KindCaret,
    KindPercent, KindAmp, KindCaretEq, KindPercentEq, KindAmpEq, KindOrOr,
    KindOrOrEq, KindSlash, KindStar, KindPipe, KindSlashEq, KindStarEq,
    KindPipeEq, KindAssign, KindEqEq, KindLt, KindShl, KindLe, KindShlEq,
    KindGt, KindShr, KindGe, KindShrEq, KindQuestion, KindComma, KindDot,
    KindColon, KindScope, KindSemi, KindArrow, KindWord, KindInt, KindEos
  } token_kind_e;

  typedef enum logic [1:0] {
    RunNone,
    RunWord,
    RunInt
  } run_mode_e;

  localparam logic [7:0] ChNul     = 8'h00;
  localparam logic [7:0] ChEq      = 8'h3D;
  localparam logic [7:0] ChGt      = 8'h3E;
  localparam logic [7:0] CtrlLimit = 8'h20;
  localparam logic [7:0] AsciiEnd  = 8'h80;

  typedef struct packed {
    logic [7:0]  held_char;
    logic [1:0]  held_count;
    run_mode_e   run_mode;
    logic [31:0] token_start;
    logic [31:0] byte_position;
  } lex_state_t;

  localparam lex_state_t ResetState = '{
    held_char:     8'h00,
    held_count:    2'd0,
    run_mode:      RunNone,
    token_start:   32'd0,
    byte_position: 32'd0
  };

  typedef struct packed {
    token_kind_e kind;
    logic [31:0] begin_pos;
    logic [31:0] token_len;
    logic        bad_byte;
    logic        last;
  } result_t;

  // What one accepted byte produces: zero, one or two results.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } step_out_t;

  typedef struct packed {
    logic        found;
    token_kind_e bare;
    token_kind_e rep;
    token_kind_e fol;
    token_kind_e rf;
  } op_entry_t;

  // Operator table: plain form, doubled form, form with follow character,
  // and doubled form with follow character.
  function automatic op_entry_t op_lookup(logic [7:0] c);
    op_entry_t e;
    e = '{1'b0, KindInvalid, KindInvalid, KindInvalid, KindInvalid};
    case (c)
      8'h28: e = '{1'b1, KindLParen, KindLParen, KindLParen, KindLParen};
      8'h29: e = '{1'b1, KindRParen, KindRParen, KindRParen, KindRParen};
      8'h5B: e = '{1'b1, KindLBrack, KindLBrack, KindLBrack, KindLBrack};
      8'h5D: e = '{1'b1, KindRBrack, KindRBrack, KindRBrack, KindRBrack};
      8'h7B: e = '{1'b1, KindLBrace, KindLBrace, KindLBrace, KindLBrace};
      8'h7D: e = '{1'b1, KindRBrace, KindRBrace, KindRBrace, KindRBrace};
      8'h7E: e = '{1'b1, KindTilde, KindTilde, KindTilde, KindTilde};
      8'h3F: e = '{1'b1, KindQuestion, KindQuestion, KindQuestion, KindQuestion};
      8'h2C: e = '{1'b1, KindComma, KindComma, KindComma, KindComma};
      8'h2E: e = '{1'b1, KindDot, KindDot, KindDot, KindDot};
      8'h3B: e = '{1'b1, KindSemi, KindSemi, KindSemi, KindSemi};
      8'h3A: e = '{1'b1, KindColon, KindScope, KindColon, KindScope};
      8'h5E: e = '{1'b1, KindCaret, KindCaret, KindCaretEq, KindCaret};
      8'h21: e = '{1'b1, KindBang, KindBang, KindNotEq, KindBang};
      8'h25: e = '{1'b1, KindPercent, KindPercent, KindPercentEq, KindPercent};
      8'h2F: e = '{1'b1, KindSlash, KindSlash, KindSlashEq, KindSlash};
      8'h2A: e = '{1'b1, KindStar, KindStar, KindStarEq, KindStar};
      8'h3D: e = '{1'b1, KindAssign, KindEqEq, KindArrow, KindEqEq};
      8'h2B: e = '{1'b1, KindPlus, KindIncr, KindPlusEq, KindIncr};
      8'h2D: e = '{1'b1, KindMinus, KindDecr, KindMinusEq, KindDecr};
      8'h26: e = '{1'b1, KindAmp, KindAndAnd, KindAmpEq, KindAndAndEq};
      8'h7C: e = '{1'b1, KindPipe, KindOrOr, KindPipeEq, KindOrOrEq};
      8'h3C: e = '{1'b1, KindLt, KindShl, KindLe, KindShlEq};
      8'h3E: e = '{1'b1, KindGt, KindShr, KindGe, KindShrEq};
      default: e = '{1'b0, KindInvalid, KindInvalid, KindInvalid, KindInvalid};
    endcase
    return e;
  endfunction

endpackage

### sv/olex_step.sv
// ----------------------------------------------------------------------------
// Lexer step
// Works out, for one source byte, the next lexer state and up to two tokens.
// ----------------------------------------------------------------------------
module olex_step (
  input  olex_pkg::lex_state_t state_i,
  input  logic [7:0]           byte_i,
  output olex_pkg::lex_state_t state_o,
  output olex_pkg::step_out_t  out_o
);

  function automatic logic is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_word_head(logic [7:0] c);
    return is_letter(c) || c == 8'h5F || c == 8'h24;
  endfunction

  function automatic olex_pkg::result_t mk(olex_pkg::token_kind_e kind, logic [31:0] pos,
                                           logic [31:0] len, logic bad);
    olex_pkg::result_t r;
    r = '{kind: kind, begin_pos: pos, token_len: len, bad_byte: bad, last: 1'b0};
    return r;
  endfunction

  olex_pkg::lex_state_t st;
  olex_pkg::result_t    res [2];
  olex_pkg::op_entry_t  held_e;
  olex_pkg::op_entry_t  new_e;
  logic [1:0]           n;
  logic                 used;
  logic [7:0]           follow;
  logic [31:0]          p;
  logic                 is_space;

  always_comb begin
    st       = state_i;
    res[0]   = mk(olex_pkg::KindInvalid, 32'd0, 32'd0, 1'b0);
    res[1]   = res[0];
    n        = 2'd0;
    used     = 1'b0;
    p        = state_i.byte_position;
    held_e   = olex_pkg::op_lookup(state_i.held_char);
    new_e    = olex_pkg::op_lookup(byte_i);
    follow   = (state_i.held_char == olex_pkg::ChEq) ? olex_pkg::ChGt : olex_pkg::ChEq;
    is_space = byte_i == 8'h20 || byte_i == 8'h09 || byte_i == 8'h0A || byte_i == 8'h0D;

    // Offer the byte to the pending token first.
    if (state_i.run_mode == olex_pkg::RunWord || state_i.run_mode == olex_pkg::RunInt) begin
      if (state_i.run_mode == olex_pkg::RunWord ?
          (is_word_head(byte_i) || is_digit(byte_i)) :
          (is_letter(byte_i) || is_digit(byte_i) || byte_i == 8'h27)) begin
        used = 1'b1;
      end else begin
        res[0] = mk(state_i.run_mode == olex_pkg::RunWord ? olex_pkg::KindWord
                                                           : olex_pkg::KindInt,
                    state_i.token_start, p - state_i.token_start, 1'b0);
        n = 2'd1;
        st.run_mode = olex_pkg::RunNone;
      end
    end else begin
      st.run_mode = olex_pkg::RunNone;
      if (state_i.held_count == 2'd1) begin
        if (byte_i == state_i.held_char && held_e.rep != held_e.bare) begin
          if (held_e.rf != held_e.rep) begin
            st.held_count = 2'd2;
          end else begin
            res[0] = mk(held_e.rep, state_i.token_start, 32'd2, 1'b0);
            n = 2'd1;
            st.held_count = 2'd0;
          end
          used = 1'b1;
        end else begin
          st.held_count = 2'd0;
          n = 2'd1;
          if (byte_i == follow && held_e.fol != held_e.bare) begin
            res[0] = mk(held_e.fol, state_i.token_start, 32'd2, 1'b0);
            used = 1'b1;
          end else begin
            res[0] = mk(held_e.bare, state_i.token_start, 32'd1, 1'b0);
          end
        end
      end else if (state_i.held_count == 2'd2) begin
        st.held_count = 2'd0;
        n = 2'd1;
        if (byte_i == follow) begin
          res[0] = mk(held_e.rf, state_i.token_start, 32'd3, 1'b0);
          used = 1'b1;
        end else begin
          res[0] = mk(held_e.rep, state_i.token_start, 32'd2, 1'b0);
        end
      end else begin
        st.held_count = 2'd0;
      end
    end

    // A byte the pending token did not take starts afresh.
    if (!used) begin
      if (byte_i == olex_pkg::ChNul) begin
        res[n[0]] = mk(olex_pkg::KindEos, p, 32'd0, 1'b0);
        n = n + 2'd1;
      end else if (is_space) begin
        st.held_count = st.held_count;
      end else if (byte_i < olex_pkg::CtrlLimit || byte_i >= olex_pkg::AsciiEnd) begin
        res[n[0]] = mk(olex_pkg::KindInvalid, p, 32'd1, 1'b1);
        n = n + 2'd1;
      end else if (is_word_head(byte_i)) begin
        st.run_mode    = olex_pkg::RunWord;
        st.token_start = p;
      end else if (is_digit(byte_i)) begin
        st.run_mode    = olex_pkg::RunInt;
        st.token_start = p;
      end else if (new_e.found) begin
        if (new_e.rep != new_e.bare || new_e.fol != new_e.bare) begin
          st.held_char   = byte_i;
          st.held_count  = 2'd1;
          st.token_start = p;
        end else begin
          res[n[0]] = mk(new_e.bare, p, 32'd1, 1'b0);
          n = n + 2'd1;
        end
      end else begin
        res[n[0]] = mk(olex_pkg::KindInvalid, p, 32'd1, 1'b0);
        n = n + 2'd1;
      end
    end

    st.byte_position = (byte_i == olex_pkg::ChNul) ? 32'd0 : p + 32'd1;

    if (n == 2'd1) begin
      res[0].last = 1'b1;
    end else if (n == 2'd2) begin
      res[1].last = 1'b1;
    end
  end

  assign state_o      = st;
  assign out_o.count  = n;
  assign out_o.first  = res[0];
  assign out_o.second = res[1];

endmodule

### sv/olex_fifo.sv
// ----------------------------------------------------------------------------
// Token queue
// Small queue that takes up to two tokens a cycle and hands out one.
// ----------------------------------------------------------------------------
module olex_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  olex_pkg::step_out_t push_i,
  input  logic                pop_i,
  output olex_pkg::result_t   head_o,
  output logic                valid_o,
  output logic                room2_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  olex_pkg::result_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_next;
  logic [CntW-1:0]   count_q, count_d;

  function automatic logic [PtrW-1:0] step_ptr(logic [PtrW-1:0] ptr);
    return (ptr == PtrW'(Depth - 1)) ? '0 : ptr + 1'b1;
  endfunction

  always_comb begin
    wr_next  = step_ptr(wr_ptr_q);
    wr_ptr_d = wr_ptr_q;
    case (push_i.count)
      2'd1:    wr_ptr_d = wr_next;
      2'd2:    wr_ptr_d = step_ptr(wr_next);
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = pop_i ? step_ptr(rd_ptr_q) : rd_ptr_q;
    count_d  = count_q + CntW'(push_i.count) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.second;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = count_q != '0;
  assign room2_o = count_q <= CntW'(Depth - 2);

endmodule

### sv/operator_token_lexer.sv
// ----------------------------------------------------------------------------
// Operator token lexer
// Streaming maximal-munch tokenizer: source bytes in, tokens out.
// ----------------------------------------------------------------------------
// Usage: source bytes arrive one per request on the slave stream, tdata[7:0].
// Each byte may finish zero, one or two tokens; tokens leave on the master
// stream with kind, start offset and length in tdata, the bad-byte flag in
// tuser, and tlast set on the final token caused by a given byte. A zero byte
// ends the source: it flushes any pending token, sends an end-of-source token
// and restarts the offset count at zero.
// Output: tokens that a byte ends are written into the token queue and leave
// it in order. Throughput: one byte per cycle while two queue places are free.
// The lexer state update is a single pass of logic between the state register
// and the token queue; the output moves one token per cycle, so the tokens of
// a byte that ends two leave in turn and the queue absorbs the difference.
// Stalls: while the receiver holds tready low, tokens wait in a queue of
// FifoDepth entries; the input stays ready as long as two free places
// remain, so no token is ever dropped.
// Reset: asynchronous, active low; clears the lexer state, the offset count
// and the queue. The block is ready as soon as reset is released.
module operator_token_lexer #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] source_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [5:0] token_kind, [37:6] begin_pos,
                                      // [69:38] token_len, [71:70] zero
  output logic        m_axis_tuser,   // [0] bad_byte
  output logic        m_axis_tlast
);

  olex_pkg::lex_state_t state_q, state_d;
  olex_pkg::step_out_t  step_out, push;
  olex_pkg::result_t    head;
  logic                 s_fire, m_fire, room2;

  assign s_fire        = s_axis_tvalid & s_axis_tready;
  assign m_fire        = m_axis_tvalid & m_axis_tready;
  assign s_axis_tready = room2;

  // Combinational lexer step on the current state and the offered byte.
  olex_step u_step (
    .state_i (state_q),
    .byte_i  (s_axis_tdata),
    .state_o (state_d),
    .out_o   (step_out)
  );

  // Only an accepted byte pushes tokens into the queue.
  always_comb begin
    push = step_out;
    if (!s_fire) begin
      push.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= olex_pkg::ResetState;
    end else if (s_fire) begin
      state_q <= state_d;
    end
  end

  olex_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (m_fire),
    .head_o  (head),
    .valid_o (m_axis_tvalid),
    .room2_o (room2)
  );

  assign m_axis_tdata = {2'b00, head.token_len, head.begin_pos, head.kind};
  assign m_axis_tuser = head.bad_byte;
  assign m_axis_tlast = head.last;

`ifndef SYNTHESIS
  // A word or literal run and a held operator never coexist.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.run_mode != olex_pkg::RunNone |-> state_q.held_count == 2'd0)
    else $error("run mode active while an operator is held");

  // The held count only ever reaches one or two.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.held_count != 2'd3)
    else $error("held count out of range");

  // A byte that finishes a token makes a token available next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && step_out.count != 2'd0 |=> m_axis_tvalid)
    else $error("token lost after accepted byte");

  // End of source restarts the offset count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire && s_axis_tdata == olex_pkg::ChNul |=> state_q.byte_position == 32'd0)
    else $error("offset not restarted at end of source");
`endif

endmodule
